FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the occlusion block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/core/scso_pkg.sv
// Types and constants of the solid column span occlusion block.
// No dependencies; imported by every module of the block.
package scso_pkg;

  localparam int COL_W       = 16;
  localparam int FRAG_W      = 7;
  localparam int ENTRY_W     = 8;
  localparam int POS_W       = ENTRY_W + 1;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  localparam logic CMD_CLEAR = 1'b1;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [3:0] {
    ST_CLR0,
    ST_CLR1,
    ST_CLR2,
    ST_IDLE,
    ST_START,
    ST_LOOP,
    ST_NXT,
    ST_DECIDE,
    ST_EMIT,
    ST_MRG_A,
    ST_MRG_R,
    ST_MRG_W,
    ST_MRG_W2,
    ST_ADV,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_NXT_CAP,
    OP_EMIT,
    OP_MRG_STOP,
    OP_MRG_RD,
    OP_MRG_PREV,
    OP_MRG_LO,
    OP_ADV,
    OP_FIN
  } dp_op_t;

  typedef enum logic [1:0] {
    RD_NEG1,
    RD_CUR,
    RD_NXT
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_CLR0,
    WR_CLR1,
    WR_CLR2,
    WR_STOP,
    WR_CUR,
    WR_LO,
    WR_PREV
  } wr_sel_t;

  typedef struct packed {
    dp_op_t  op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic seg_off;
    logic start_hidden;
    logic cur_end;
    logic hit;
    logic solid_run;
    logic seg_solid;
    logic nxt_past_hi;
    logic stop_lt_nxt;
    logic lo_gt_cur;
    logic pend_v;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/core/scso_ctrl.sv
// Sequencer of the occlusion block: walks the run list and drives the datapath.
// Depends on scso_pkg for the state, command and status types.
module scso_ctrl import scso_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   reply_r, reply_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR0;
      reply_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      reply_r <= reply_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    reply_nxt  = reply_r;
    in_tready  = 1'b0;
    cmd.op     = OP_NONE;
    cmd.rd_en  = 1'b0;
    cmd.rd_sel = RD_CUR;
    cmd.wr_en  = 1'b0;
    cmd.wr_sel = WR_CLR0;
    unique case (state_r)
      ST_CLR0: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_CLR0;
        state_nxt  = ST_CLR1;
      end
      ST_CLR1: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_CLR1;
        state_nxt  = ST_CLR2;
      end
      ST_CLR2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_CLR2;
        reply_nxt  = 1'b0;
        state_nxt  = reply_r ? ST_FIN : ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = OP_LOAD;
          if (stat.is_clear) begin
            reply_nxt = 1'b1;
            state_nxt = ST_CLR0;
          end else if (stat.seg_off) begin
            state_nxt = ST_FIN;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NEG1;
            state_nxt  = ST_START;
          end
        end
      end
      ST_START: begin
        if (stat.start_hidden) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.op    = OP_START;
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (stat.cur_end) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CUR;
          state_nxt  = ST_NXT;
        end
      end
      ST_NXT: begin
        cmd.op    = OP_NXT_CAP;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat.hit && !stat.solid_run) begin
          state_nxt = ST_EMIT;
        end else if (stat.nxt_past_hi) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.op    = OP_ADV;
          state_nxt = ST_LOOP;
        end
      end
      ST_EMIT: begin
        if (!stat.pend_v || stat.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = stat.seg_solid ? ST_MRG_A : ST_ADV;
        end
      end
      ST_MRG_A: begin
        if (stat.stop_lt_nxt) begin
          cmd.op     = OP_MRG_STOP;
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_STOP;
          state_nxt  = ST_MRG_W;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NXT;
          state_nxt  = ST_MRG_R;
        end
      end
      ST_MRG_R: begin
        cmd.op    = OP_MRG_RD;
        state_nxt = ST_MRG_W;
      end
      ST_MRG_W: begin
        cmd.wr_en = 1'b1;
        if (stat.lo_gt_cur) begin
          cmd.wr_sel = WR_CUR;
          state_nxt  = ST_MRG_W2;
        end else begin
          cmd.wr_sel = WR_PREV;
          cmd.op     = OP_MRG_PREV;
          state_nxt  = ST_ADV;
        end
      end
      ST_MRG_W2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_LO;
        cmd.op     = OP_MRG_LO;
        state_nxt  = ST_ADV;
      end
      ST_ADV: begin
        if (stat.nxt_past_hi) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.op    = OP_ADV;
          state_nxt = ST_LOOP;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.op    = OP_FIN;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/scso_dp.sv
// Datapath of the occlusion block: run map memory, walk registers, result staging.
// Depends on scso_pkg; commanded by scso_ctrl.
module scso_dp import scso_pkg::*; #(
  parameter int SCREEN_WIDTH = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tuser,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat
);

  localparam int DEPTH = SCREEN_WIDTH + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam pos_t LEFT_EDGE  = pos_t'(-1);
  localparam pos_t RIGHT_EDGE = pos_t'(SCREEN_WIDTH);
  localparam pos_t PAST_EDGE  = pos_t'(SCREEN_WIDTH + 1);
  localparam pos_t LAST_COL   = pos_t'(SCREEN_WIDTH - 1);
  localparam logic signed [COL_W-1:0] LAST_COL_IN = COL_W'(SCREEN_WIDTH - 1);

  logic signed [COL_W-1:0] col_a, col_b, col_lo, col_hi;
  pos_t clip_lo, clip_hi;
  logic is_solid;

  pos_t lo_r, hi_r, stop_r, prev_r, cur_r, nxt_r, mrg_r;
  pos_t lo_nxt, hi_nxt, stop_nxt, prev_nxt, cur_nxt, nxt_nxt, mrg_nxt;
  logic solid_r, solid_nxt, seg_solid_r, seg_solid_nxt;
  logic pend_v_r, pend_v_nxt;
  logic [FRAG_W-1:0] pend_first_r, pend_first_nxt, pend_last_r, pend_last_nxt;
  logic out_valid_r, out_valid_nxt, out_has_r, out_has_nxt, out_end_r, out_end_nxt;
  logic [FRAG_W-1:0] out_first_r, out_first_nxt, out_last_r, out_last_nxt;

  logic [ENTRY_W-1:0] mem_r [DEPTH];
  logic [ENTRY_W-1:0] mem_q_r;
  logic rd_oob_r;
  pos_t rd_val, rd_pos, wr_pos, wr_val, rd_idx, wr_idx, frag_end;
  logic rd_in, wr_in;
  logic [AW-1:0] rd_addr, wr_addr;
  logic out_free;

  assign col_a    = $signed(in_tdata[COL_W-1:0]);
  assign col_b    = $signed(in_tdata[2*COL_W-1:COL_W]);
  assign is_solid = in_tdata[2*COL_W];
  assign col_lo   = (col_b < col_a) ? col_b : col_a;
  assign col_hi   = (col_b < col_a) ? col_a : col_b;
  assign clip_lo  = col_lo[COL_W-1] ? pos_t'(0) : pos_t'(col_lo[POS_W-1:0]);
  assign clip_hi  = (col_hi > LAST_COL_IN) ? LAST_COL : pos_t'(col_hi[POS_W-1:0]);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_NEG1: rd_pos = LEFT_EDGE;
      RD_CUR:  rd_pos = cur_r;
      RD_NXT:  rd_pos = nxt_r;
      default: rd_pos = LEFT_EDGE;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      WR_CLR0: begin
        wr_pos = LEFT_EDGE;
        wr_val = pos_t'(0);
      end
      WR_CLR1: begin
        wr_pos = pos_t'(0);
        wr_val = RIGHT_EDGE;
      end
      WR_CLR2: begin
        wr_pos = RIGHT_EDGE;
        wr_val = PAST_EDGE;
      end
      WR_STOP: begin
        wr_pos = stop_r;
        wr_val = nxt_r;
      end
      WR_CUR: begin
        wr_pos = cur_r;
        wr_val = lo_r;
      end
      WR_LO: begin
        wr_pos = lo_r;
        wr_val = mrg_r;
      end
      WR_PREV: begin
        wr_pos = prev_r;
        wr_val = mrg_r;
      end
      default: begin
        wr_pos = LEFT_EDGE;
        wr_val = pos_t'(0);
      end
    endcase
  end

  assign rd_idx  = rd_pos + pos_t'(1);
  assign wr_idx  = wr_pos + pos_t'(1);
  assign rd_in   = (rd_pos >= LEFT_EDGE) && (rd_pos <= RIGHT_EDGE);
  assign wr_in   = (wr_pos >= LEFT_EDGE) && (wr_pos <= RIGHT_EDGE);
  assign rd_addr = rd_in ? rd_idx[AW-1:0] : '0;
  assign wr_addr = wr_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_in) begin
      mem_r[wr_addr] <= wr_val[ENTRY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      mem_q_r  <= mem_r[rd_addr];
      rd_oob_r <= !rd_in;
    end
  end

  // Positions outside the map read as the end of the walk.
  assign rd_val   = rd_oob_r ? PAST_EDGE : pos_t'({1'b0, mem_q_r});
  assign frag_end = ((stop_r < nxt_r) ? stop_r : nxt_r) - pos_t'(1);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    stop_nxt       = stop_r;
    prev_nxt       = prev_r;
    cur_nxt        = cur_r;
    nxt_nxt        = nxt_r;
    mrg_nxt        = mrg_r;
    solid_nxt      = solid_r;
    seg_solid_nxt  = seg_solid_r;
    pend_v_nxt     = pend_v_r;
    pend_first_nxt = pend_first_r;
    pend_last_nxt  = pend_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_first_nxt  = out_first_r;
    out_last_nxt   = out_last_r;
    out_has_nxt    = out_has_r;
    out_end_nxt    = out_end_r;
    unique case (cmd.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        lo_nxt        = clip_lo;
        hi_nxt        = clip_hi;
        stop_nxt      = clip_hi + pos_t'(1);
        prev_nxt      = LEFT_EDGE;
        solid_nxt     = 1'b0;
        seg_solid_nxt = is_solid;
        pend_v_nxt    = 1'b0;
      end
      OP_START: begin
        cur_nxt = rd_val;
        if (lo_r < rd_val) begin
          lo_nxt = rd_val;
        end
      end
      OP_NXT_CAP: begin
        nxt_nxt = rd_val;
      end
      OP_EMIT: begin
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_first_nxt = pend_first_r;
          out_last_nxt  = pend_last_r;
          out_has_nxt   = 1'b1;
          out_end_nxt   = 1'b0;
        end
        pend_v_nxt     = 1'b1;
        pend_first_nxt = lo_r[FRAG_W-1:0];
        pend_last_nxt  = frag_end[FRAG_W-1:0];
      end
      OP_MRG_STOP: begin
        mrg_nxt = stop_r;
      end
      OP_MRG_RD: begin
        mrg_nxt = rd_val;
      end
      OP_MRG_PREV: begin
        cur_nxt   = prev_r;
        lo_nxt    = mrg_r;
        nxt_nxt   = mrg_r;
        solid_nxt = 1'b1;
      end
      OP_MRG_LO: begin
        cur_nxt   = lo_r;
        lo_nxt    = mrg_r;
        nxt_nxt   = mrg_r;
        solid_nxt = 1'b1;
      end
      OP_ADV: begin
        if (lo_r < nxt_r) begin
          lo_nxt = nxt_r;
        end
        prev_nxt  = cur_r;
        cur_nxt   = nxt_r;
        solid_nxt = !solid_r;
      end
      OP_FIN: begin
        out_valid_nxt = 1'b1;
        out_first_nxt = pend_v_r ? pend_first_r : '0;
        out_last_nxt  = pend_v_r ? pend_last_r : '0;
        out_has_nxt   = pend_v_r;
        out_end_nxt   = 1'b1;
        pend_v_nxt    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    stop_r       <= stop_nxt;
    prev_r       <= prev_nxt;
    cur_r        <= cur_nxt;
    nxt_r        <= nxt_nxt;
    mrg_r        <= mrg_nxt;
    solid_r      <= solid_nxt;
    seg_solid_r  <= seg_solid_nxt;
    pend_first_r <= pend_first_nxt;
    pend_last_r  <= pend_last_nxt;
    out_first_r  <= out_first_nxt;
    out_last_r   <= out_last_nxt;
    out_has_r    <= out_has_nxt;
    out_end_r    <= out_end_nxt;
  end

  assign stat.is_clear     = (in_tuser == CMD_CLEAR);
  assign stat.seg_off      = col_hi[COL_W-1] || (col_lo > LAST_COL_IN);
  assign stat.start_hidden = rd_val > hi_r;
  assign stat.cur_end      = cur_r > RIGHT_EDGE;
  assign stat.hit          = lo_r < nxt_r;
  assign stat.solid_run    = solid_r;
  assign stat.seg_solid    = seg_solid_r;
  assign stat.nxt_past_hi  = hi_r < nxt_r;
  assign stat.stop_lt_nxt  = stop_r < nxt_r;
  assign stat.lo_gt_cur    = lo_r > cur_r;
  assign stat.pend_v       = pend_v_r;
  assign stat.out_free     = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2*FRAG_W){1'b0}}, out_last_r, out_first_r};
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_end_r;

endmodule

FILE: rtl/core/solid_column_span_occlusion.sv
// Solid column span occlusion map. After reset the block writes the screen borders into
// its run map in states ST_CLR0 to ST_CLR2 and only then raises in_tready. A segment is
// processed one item at a time by walking the run list from the left border: each run
// visited passes ST_LOOP, ST_NXT and ST_DECIDE, as the run memory has a registered read;
// a visible fragment adds ST_EMIT and ST_ADV, and the merge states ST_MRG_A to ST_MRG_W2
// when a solid segment merges it into the map. A clear command rewrites the borders; it
// and an off-screen segment end in ST_FIN. Each command ends with a result whose tlast is
// set; the result register lets the next command start while the last result waits.
// Depends on scso_pkg, scso_ctrl and scso_dp.
module solid_column_span_occlusion import scso_pkg::*; #(
  parameter int SCREEN_WIDTH = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // first_column, last_column, is_solid, zero pad
  input  logic                   in_tuser,   // command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // fragment_first, fragment_last, zero pad
  output logic                   out_tuser,  // has_fragment
  output logic                   out_tlast   // last_of_run
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  scso_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  scso_dp #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

FILE: rtl/core/scso_checker.sv
// Port-level assertions for the occlusion block, bound to the top level.
// Depends on scso_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scso_checker import scso_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  logic [FRAG_W-1:0] frag_first, frag_last;

  assign frag_first = out_tdata[FRAG_W-1:0];
  assign frag_last  = out_tdata[2*FRAG_W-1:FRAG_W];

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_SAME(a_empty_is_last, clk, rst_n, out_tvalid && !out_tuser, out_tlast)
  `ASSERT_SAME(a_frag_order, clk, rst_n, out_tvalid && out_tuser, frag_first <= frag_last)
  `ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule

bind solid_column_span_occlusion scso_checker u_scso_checker (.*);
